// ===== rtl/triangle_weight_cutoff_clipper_top_defines.svh =====
// assertion macros shared by the clipper rtl
`ifndef TRIANGLE_WEIGHT_CUTOFF_CLIPPER_TOP_DEFINES_SVH
`define TRIANGLE_WEIGHT_CUTOFF_CLIPPER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define TWCC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twcc check failed");
// next-cycle implication
`define TWCC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twcc check failed");
`else
`define TWCC_ASSERT_NOW(name, ante, cons)
`define TWCC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/twcc_pkg.sv =====
package twcc_pkg;

  localparam int NSTG       = 16;
  localparam int NLANE      = 8;
  localparam int DIV_FIRST  = 4;
  localparam int DIV_LAST   = 14;
  localparam int DIV_STEPS  = 3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ALL  = 2'd1;
  localparam logic [1:0] MODE_ONE  = 2'd2;
  localparam logic [1:0] MODE_TWO  = 2'd3;

  typedef struct packed {
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] a_w;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] b_w;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [31:0] c_z;
    logic [31:0] c_w;
  } in_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;
    logic        ends_triangle;
    logic        last_vertex;
  } out_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } vtx_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
  } xc_t;

  typedef struct packed {
    logic [31:0] base;
    logic        neg;
    logic        hi;
    logic [64:0] prod;
    logic [31:0] rem;
    logic [32:0] qs;
  } lane_t;

  typedef struct packed {
    logic [1:0]  mode;
    vtx_t        ka;
    vtx_t        kb;
    vtx_t        kc;
    vtx_t [1:0]  dv;
    vtx_t [1:0]  kv;
    xc_t  [1:0]  xc;
    lane_t [NLANE-1:0] ln;
  } item_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] qs;
  } div_t;

  function automatic logic [31:0] comp_get(input vtx_t v, input logic [1:0] idx);
    logic [31:0] r;
    case (idx)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      2'd2:    r = v.z;
      default: r = v.w;
    endcase
    return r;
  endfunction

  // one restoring division step, quotient bit shifts into qs
  function automatic div_t div_step(input div_t d, input logic [31:0] den);
    logic [32:0] t;
    logic [32:0] r;
    logic        qb;
    div_t        o;
    t = {d.rem, d.qs[32]};
    if (t >= {1'b0, den}) begin
      r  = t - {1'b0, den};
      qb = 1'b1;
    end else begin
      r  = t;
      qb = 1'b0;
    end
    o.rem = r[31:0];
    o.qs  = {d.qs[31:0], qb};
    return o;
  endfunction

endpackage

// ===== rtl/triangle_weight_cutoff_clipper_top.sv =====
// triangle clipper against the weight plane w = cutoff_level
// input channel: in_valid / in_stall / in_data, one triangle (three vertices,
//   x y z w in signed q16.16) per beat, taken when in_valid and not in_stall
// output channel: out_valid / out_stall / out_data, one vertex per beat with
//   ends_triangle on the third vertex of each output triangle and last_vertex
//   on the final vertex of an input triangle
// config channel: cfg_valid / cfg_ready / cfg_data writes cutoff_level; always
//   ready, write only while the block is idle
// path: the first vertex of a taken triangle runs through a 16-stage
//   pipeline (classify, setup, multiply, sum, 11 divider stages of
//   3 quotient bits each, rounding) and then the output sequencer register
// throughput: while in_stall is low the pipeline takes a triangle every
//   cycle; the single output port emits 3 beats for a kept or one-kept
//   triangle, 6 for a two-kept one; a fully dropped one is discarded at the tail
// reset: rst clears valid bits, sequencer and cutoff_level (to 0)
// stall: out_stall holds the current beat; once the pipeline tail waits the
//   whole pipeline freezes and in_stall rises, nothing is lost or repeated
`include "triangle_weight_cutoff_clipper_top_defines.svh"

module triangle_weight_cutoff_clipper_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  twcc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output twcc_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);
  import twcc_pkg::*;

  // config
  logic [31:0] cutoff_level;

  // pipeline
  item_t            pipe [NSTG];
  item_t            nxt  [NSTG];
  logic [NSTG-1:0]  vld;
  logic             adv;

  // classify helpers
  vtx_t        va, vb, vc, r0, r1, r2;
  logic [2:0]  keep;
  logic [1:0]  cnt;
  logic [1:0]  kidx;

  // lane setup helpers
  logic [31:0] kcomp [NLANE];
  logic [31:0] dcomp [NLANE];
  logic [32:0] diff [NLANE];
  logic [32:0] mag  [NLANE];
  logic [32:0] nsub [2];
  logic [32:0] dsub [2];
  div_t        dv_tmp [NSTG][NLANE];
  logic        rbit [NLANE];
  logic [32:0] qfin [NLANE];

  // output sequencer
  logic [1:0]  sq_mode;
  vtx_t        sq_ka, sq_kb, sq_kc, sq_p0, sq_p1;
  logic [2:0]  beat;
  logic        sq_valid;
  logic        beat_last;
  logic        take;
  logic        out_acc;
  vtx_t        sel;
  vtx_t        tail_p0, tail_p1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cutoff_level <= cfg_data;
    end
  end

  // stage 0: keep test, case pick, rotate vertices into crossing roles
  always_comb begin
    va = '{in_data.a_x, in_data.a_y, in_data.a_z, in_data.a_w};
    vb = '{in_data.b_x, in_data.b_y, in_data.b_z, in_data.b_w};
    vc = '{in_data.c_x, in_data.c_y, in_data.c_z, in_data.c_w};
    keep[0] = $signed(va.w) >= $signed(cutoff_level);
    keep[1] = $signed(vb.w) >= $signed(cutoff_level);
    keep[2] = $signed(vc.w) >= $signed(cutoff_level);
    cnt = {1'b0, keep[0]} + {1'b0, keep[1]} + {1'b0, keep[2]};
    // k is the lone kept vertex, or the lone dropped one
    if (cnt == 2'd1) begin
      kidx = keep[0] ? 2'd0 : (keep[1] ? 2'd1 : 2'd2);
    end else begin
      kidx = !keep[0] ? 2'd0 : (!keep[1] ? 2'd1 : 2'd2);
    end
    case (kidx)
      2'd0: begin
        r0 = va; r1 = vb; r2 = vc;
      end
      2'd1: begin
        r0 = vb; r1 = vc; r2 = va;
      end
      default: begin
        r0 = vc; r1 = va; r2 = vb;
      end
    endcase

    nxt[0] = '0;
    case (cnt)
      2'd0: begin
        nxt[0].mode = MODE_NONE;
      end
      2'd1: begin
        nxt[0].mode  = MODE_ONE;
        nxt[0].ka    = r0;
        nxt[0].dv[0] = r1;
        nxt[0].kv[0] = r0;
        nxt[0].dv[1] = r2;
        nxt[0].kv[1] = r0;
      end
      2'd2: begin
        nxt[0].mode  = MODE_TWO;
        nxt[0].ka    = r2;
        nxt[0].kb    = r1;
        nxt[0].dv[0] = r0;
        nxt[0].kv[0] = r2;
        nxt[0].dv[1] = r0;
        nxt[0].kv[1] = r1;
      end
      default: begin
        nxt[0].mode = MODE_ALL;
        nxt[0].ka   = va;
        nxt[0].kb   = vb;
        nxt[0].kc   = vc;
      end
    endcase

    // stages 1 .. NSTG-1
    for (int s = 1; s < NSTG; s++) begin
      nxt[s] = pipe[s-1];
    end
    for (int c = 0; c < 2; c++) begin
      nsub[c] = {cutoff_level[31], cutoff_level} - {pipe[0].dv[c].w[31], pipe[0].dv[c].w};
      dsub[c] = {pipe[0].kv[c].w[31], pipe[0].kv[c].w} - {pipe[0].dv[c].w[31], pipe[0].dv[c].w};
    end
    for (int l = 0; l < NLANE; l++) begin
      kcomp[l] = comp_get(pipe[0].kv[l >> 2], 2'(l));
      dcomp[l] = comp_get(pipe[0].dv[l >> 2], 2'(l));
      diff[l]  = {kcomp[l][31], kcomp[l]} - {dcomp[l][31], dcomp[l]};
      mag[l]   = diff[l][32] ? (33'd0 - diff[l]) : diff[l];
    end

    // stage 1: numerator, denominator, magnitude and sign per lane
    for (int c = 0; c < 2; c++) begin
      nxt[1].xc[c].num = nsub[c][31:0];
      nxt[1].xc[c].den = dsub[c][31:0];
    end
    for (int l = 0; l < NLANE; l++) begin
      nxt[1].ln[l].base = dcomp[l];
      nxt[1].ln[l].neg  = diff[l][32];
      nxt[1].ln[l].hi   = mag[l][32];
      nxt[1].ln[l].prod = {33'd0, mag[l][31:0]};
    end

    // stage 2: low 32x32 product
    for (int l = 0; l < NLANE; l++) begin
      nxt[2].ln[l].prod = {1'b0, 64'(pipe[1].ln[l].prod[31:0]) * 64'(pipe[1].xc[l >> 2].num)};
    end

    // stage 3: add top magnitude bit, seed divider
    for (int l = 0; l < NLANE; l++) begin
      nxt[3].ln[l].prod = pipe[2].ln[l].prod
                        + (pipe[2].ln[l].hi ? {1'b0, pipe[2].xc[l >> 2].num, 32'd0} : 65'd0);
      nxt[3].ln[l].rem  = nxt[3].ln[l].prod[64:33];
      nxt[3].ln[l].qs   = nxt[3].ln[l].prod[32:0];
    end

    // divider stages, three quotient bits each
    for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        dv_tmp[s][l] = '{pipe[s-1].ln[l].rem, pipe[s-1].ln[l].qs};
        for (int st = 0; st < DIV_STEPS; st++) begin
          dv_tmp[s][l] = div_step(dv_tmp[s][l], pipe[s-1].xc[l >> 2].den);
        end
        nxt[s].ln[l].rem = dv_tmp[s][l].rem;
        nxt[s].ln[l].qs  = dv_tmp[s][l].qs;
      end
    end
    for (int s = 0; s < DIV_FIRST; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        dv_tmp[s][l] = '0;
      end
    end
    for (int s = DIV_LAST + 1; s < NSTG; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        dv_tmp[s][l] = '0;
      end
    end

    // last stage: round half away from zero, apply sign
    for (int l = 0; l < NLANE; l++) begin
      rbit[l] = {pipe[NSTG-2].ln[l].rem, 1'b0} >= {1'b0, pipe[NSTG-2].xc[l >> 2].den};
      qfin[l] = pipe[NSTG-2].ln[l].qs + {32'd0, rbit[l]};
      nxt[NSTG-1].ln[l].base = pipe[NSTG-2].ln[l].neg
                             ? pipe[NSTG-2].ln[l].base - qfin[l][31:0]
                             : pipe[NSTG-2].ln[l].base + qfin[l][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NSTG; s++) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  // crossing vertices at the pipeline tail
  assign tail_p0 = '{pipe[NSTG-1].ln[0].base, pipe[NSTG-1].ln[1].base,
                     pipe[NSTG-1].ln[2].base, pipe[NSTG-1].ln[3].base};
  assign tail_p1 = '{pipe[NSTG-1].ln[4].base, pipe[NSTG-1].ln[5].base,
                     pipe[NSTG-1].ln[6].base, pipe[NSTG-1].ln[7].base};

  // output sequencer: holds one triangle and walks its beats
  assign out_acc   = sq_valid && !out_stall;
  assign beat_last = (sq_mode == MODE_TWO) ? (beat == 3'd5) : (beat == 3'd2);
  assign take      = !sq_valid || (out_acc && beat_last);
  assign adv       = !vld[NSTG-1] || take;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      beat     <= '0;
    end else if (take) begin
      sq_valid <= vld[NSTG-1] && (pipe[NSTG-1].mode != MODE_NONE);
      beat     <= '0;
    end else if (out_acc) begin
      beat <= beat + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sq_mode <= pipe[NSTG-1].mode;
      sq_ka   <= pipe[NSTG-1].ka;
      sq_kb   <= pipe[NSTG-1].kb;
      sq_kc   <= pipe[NSTG-1].kc;
      sq_p0   <= tail_p0;
      sq_p1   <= tail_p1;
    end
  end

  // beat order: all kept a b c; one kept k p0 p1; two kept k2 p0 p1 k2 p1 k1
  always_comb begin
    case (beat)
      3'd0:    sel = sq_ka;
      3'd1:    sel = (sq_mode == MODE_ALL) ? sq_kb : sq_p0;
      3'd2:    sel = (sq_mode == MODE_ALL) ? sq_kc : sq_p1;
      3'd3:    sel = sq_ka;
      3'd4:    sel = sq_p1;
      default: sel = sq_kb;
    endcase
  end

  assign out_valid              = sq_valid;
  assign out_data.out_x         = sel.x;
  assign out_data.out_y         = sel.y;
  assign out_data.out_z         = sel.z;
  assign out_data.out_w         = sel.w;
  assign out_data.ends_triangle = (beat == 3'd2) || (beat == 3'd5);
  assign out_data.last_vertex   = beat_last;

  `TWCC_ASSERT_NOW(a_beat_range, sq_valid && (sq_mode != MODE_TWO), beat <= 3'd2)
  `TWCC_ASSERT_NOW(a_no_empty_seq, sq_valid, sq_mode != MODE_NONE)
  `TWCC_ASSERT_NOW(a_last_ends, out_valid && out_data.last_vertex, out_data.ends_triangle)
  `TWCC_ASSERT_NEXT(a_tail_holds, vld[NSTG-1] && !adv, vld[NSTG-1])

endmodule
